// ===== rtl/core/sstf_pkg.sv =====
// Shared types and constants for the shortest-seek-first scheduler.
// No dependencies; imported by the top level of the block.
`timescale 1ns / 1ps

package sstf_pkg;

  // Field widths fixed by the request and result formats
  localparam int CYL_BITS   = 10;
  localparam int DIST_BITS  = 10;
  localparam int TOTAL_BITS = 16;

  localparam int MAX_REQUESTS_DEF = 16;
  localparam logic [CYL_BITS-1:0]   START_CYL_RESET = CYL_BITS'(500);
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX       = '1;

  typedef struct packed {
    logic [CYL_BITS-1:0] cylinder;
    logic                last;
  } req_t;

  typedef struct packed {
    logic [CYL_BITS-1:0]   served_cylinder;
    logic [DIST_BITS-1:0]  seek_distance;
    logic [TOTAL_BITS-1:0] running_total;
    logic                  overflow;
    logic                  final_res;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SERVE
  } state_t;

endpackage

// ===== rtl/core/sstf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sstf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/shortest_seek_first_scheduler_top.sv =====
// Top level of the shortest-seek-first scheduler: batch store, scan and serve control.
// Depends on sstf_pkg and sstf_ram.
`timescale 1ns / 1ps

// Requests are taken one per cycle with start while busy is low; a request that
// is not marked last only goes into the store and returns nothing. A request
// marked last closes the batch: the arm is placed at start_cylinder and the
// batch of n requests is served nearest first, ties to the lowest store slot.
// Each pick re-scans the unserved entries through the single read port of the
// request RAM, one entry per cycle, and busy stays high until the whole batch
// has been served. Every result appears on result for exactly one cycle with
// done high; there is no back-pressure, so the receiver must take it then.
// Requests beyond MAX_REQUESTS are dropped and flag overflow on every result
// of that batch. start_cylinder is written through cfg_valid/cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
module shortest_seek_first_scheduler_top
  import sstf_pkg::*;
#(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  req_t                req,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CYL_BITS-1:0] cfg_data,
  output logic                done,
  output res_t                result
);

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  function automatic logic [DIST_BITS-1:0] abs_diff(input logic [CYL_BITS-1:0] a,
                                                    input logic [CYL_BITS-1:0] b);
    abs_diff = (a > b) ? DIST_BITS'(a - b) : DIST_BITS'(b - a);
  endfunction

  state_t state, state_next;

  logic [CYL_BITS-1:0]  start_cyl;
  logic [CNT_W-1:0]     req_count;
  logic                 ovf;
  logic [CNT_W-1:0]     serve_idx;
  logic [CNT_W-1:0]     rd_ptr;
  logic                 rd_vld;
  logic                 rd_first;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [CYL_BITS-1:0]  arm;
  logic [TOTAL_BITS-1:0] total;
  logic [CYL_BITS-1:0]  best_val;
  logic [DIST_BITS-1:0] best_d;
  logic [IDX_W-1:0]     best_idx;
  logic [CYL_BITS-1:0]  val_i;

  logic                 accept;
  logic                 store_ok;
  logic                 issue;
  logic                 scan_end;
  logic                 serve_final;
  logic [CNT_W-1:0]     serve_inc;
  logic [DIST_BITS-1:0] rd_dist;
  logic [TOTAL_BITS:0]  total_sum;
  logic [TOTAL_BITS-1:0] total_sat;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [CYL_BITS-1:0]  ram_wdata;
  logic [CYL_BITS-1:0]  ram_rdata;

  sstf_ram #(
    .WIDTH (CYL_BITS),
    .DEPTH (MAX_REQUESTS),
    .ADDR_W(IDX_W)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (issue),
    .raddr(rd_ptr[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  // Handshake and status terms
  assign accept      = start && !busy;
  assign store_ok    = req_count < CNT_MAX;
  assign scan_end    = rd_vld && (rd_ptr == req_count);
  assign serve_inc   = serve_idx + CNT_W'(1);
  assign serve_final = serve_inc == req_count;
  assign rd_dist     = abs_diff(ram_rdata, arm);
  assign total_sum   = {1'b0, total} + (TOTAL_BITS + 1)'(best_d);
  assign total_sat   = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];
  assign cfg_ready   = 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req.last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_SERVE;
        end
      end
      ST_SERVE: begin
        state_next = serve_final ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: busy, RAM write and read controls
  always_comb begin
    busy      = 1'b1;
    issue     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = req_count[IDX_W-1:0];
    ram_wdata = req.cylinder;
    case (state)
      ST_IDLE: begin
        busy   = 1'b0;
        ram_we = accept && store_ok;
      end
      ST_SCAN: begin
        issue = rd_ptr < req_count;
      end
      ST_SERVE: begin
        // move the entry at the served slot into the winner's place
        ram_we    = 1'b1;
        ram_waddr = best_idx;
        ram_wdata = val_i;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start_cyl <= START_CYL_RESET;
      req_count <= '0;
      ovf       <= 1'b0;
      rd_vld    <= 1'b0;
      done      <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      done   <= (state == ST_SERVE);
      if (cfg_valid && cfg_ready) begin
        start_cyl <= cfg_data;
      end
      if (accept) begin
        if (store_ok) begin
          req_count <= req_count + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (state == ST_SERVE && serve_final) begin
        req_count <= '0;
        ovf       <= 1'b0;
      end
    end
  end

  // Scan pointers, arm position, running total and the best candidate
  always_ff @(posedge clk) begin
    if (accept && req.last) begin
      serve_idx <= '0;
      rd_ptr    <= '0;
      arm       <= start_cyl;
      total     <= '0;
    end
    if (issue) begin
      rd_ptr   <= rd_ptr + CNT_W'(1);
      rd_first <= rd_ptr == serve_idx;
      rd_idx_q <= rd_ptr[IDX_W-1:0];
    end
    if (rd_vld) begin
      if (rd_first) begin
        best_val <= ram_rdata;
        best_d   <= rd_dist;
        best_idx <= rd_idx_q;
        val_i    <= ram_rdata;
      end else if (rd_dist < best_d) begin
        best_val <= ram_rdata;
        best_d   <= rd_dist;
        best_idx <= rd_idx_q;
      end
    end
    if (state == ST_SERVE) begin
      arm       <= best_val;
      total     <= total_sat;
      serve_idx <= serve_inc;
      rd_ptr    <= serve_inc;
      result.served_cylinder <= best_val;
      result.seek_distance   <= best_d;
      result.running_total   <= total_sat;
      result.overflow        <= ovf;
      result.final_res       <= serve_final;
    end
  end

  // Checks on sequencing
  a_done_after_serve: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_SERVE))
    else $error("result strobe without a serve cycle");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_ptr <= req_count && serve_idx < req_count))
    else $error("scan pointer beyond the batch");

  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    (done && result.final_res) |-> (state == ST_IDLE))
    else $error("final result but batch still active");

  a_more_to_scan: assert property (@(posedge clk) disable iff (rst)
    (done && !result.final_res) |-> (state == ST_SCAN))
    else $error("non-final result but no further scan");

endmodule
